// File: design/ppwg_pkg.sv
// ----------------------------------------------------------------------------
// ppwg_pkg
// Shared types and constants of the pulse period/width generator: command
// codes, limits, reset values and the item structs passed between modules.
// ----------------------------------------------------------------------------
package ppwg_pkg;

    localparam int PERIOD_W   = 20;
    localparam int WIDTH_W    = 10;
    localparam int PRESCALE_W = 16;
    localparam int KIND_W     = 3;

    // Limits for accepted period and width values
    localparam logic [PERIOD_W-1:0]   PERIOD_LIMIT        = 20'd1000000;
    localparam logic [WIDTH_W-1:0]    WIDTH_LIMIT         = 10'd1000;
    localparam logic [PERIOD_W-1:0]   PERIOD_MAX          = PERIOD_LIMIT - 20'd1;
    localparam logic [WIDTH_W-1:0]    WIDTH_MAX           = WIDTH_LIMIT - 10'd1;

    // Reset values
    localparam logic [PRESCALE_W-1:0] PRESCALE_RESET      = 16'd83;
    localparam logic [PERIOD_W-1:0]   PERIOD_RELOAD_RESET = 20'd100000;
    localparam logic [WIDTH_W-1:0]    WIDTH_RELOAD_RESET  = 10'd100;

    // Item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK       = 3'd0,
        KIND_START      = 3'd1,
        KIND_STOP       = 3'd2,
        KIND_SET_PERIOD = 3'd3,
        KIND_SET_WIDTH  = 3'd4
    } kind_t;

    // One input item
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [PERIOD_W-1:0] period_value;
        logic [WIDTH_W-1:0]  width_value;
    } ppwg_item_t;

    // One result item
    typedef struct packed {
        logic width_ended;
        logic period_started;
        logic pulse_level;
    } ppwg_result_t;

endpackage

// File: design/ppwg_core.sv
// ----------------------------------------------------------------------------
// ppwg_core
// Counter state of the generator: prescaled period and one-shot width
// counters, the prepared/reload values, the level and the prescale register.
// Applies one item per enabled cycle and presents its result alongside.
// ----------------------------------------------------------------------------
module ppwg_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step_en,
    input  ppwg_pkg::ppwg_item_t                item,
    input  logic                                cfg_we,
    input  logic [ppwg_pkg::PRESCALE_W-1:0]     cfg_data,
    output ppwg_pkg::ppwg_result_t              result
);
    import ppwg_pkg::*;

    logic [PRESCALE_W-1:0] prescale_div_reg;

    logic [PERIOD_W-1:0]   period_count_reg,    period_count_next;
    logic [PERIOD_W-1:0]   period_reload_reg,   period_reload_next;
    logic [PERIOD_W-1:0]   period_prepared_reg, period_prepared_next;
    logic                  period_running_reg,  period_running_next;
    logic [PRESCALE_W-1:0] period_ps_reg,       period_ps_next;

    logic [WIDTH_W-1:0]    width_count_reg,     width_count_next;
    logic [WIDTH_W-1:0]    width_reload_reg,    width_reload_next;
    logic [WIDTH_W-1:0]    width_prepared_reg,  width_prepared_next;
    logic                  width_running_reg,   width_running_next;
    logic [PRESCALE_W-1:0] width_ps_reg,        width_ps_next;

    logic                  level_reg,           level_next;
    logic                  started;
    logic                  ended;
    logic [PERIOD_W-1:0]   period_sat;
    logic [WIDTH_W-1:0]    width_sat;

    // Saturate start values to one below the limits
    assign period_sat = (item.period_value >= PERIOD_LIMIT) ? PERIOD_MAX : item.period_value;
    assign width_sat  = (item.width_value >= WIDTH_LIMIT) ? WIDTH_MAX : item.width_value;

    // Next state for the current item
    always_comb
    begin
        period_count_next    = period_count_reg;
        period_reload_next   = period_reload_reg;
        period_prepared_next = period_prepared_reg;
        period_running_next  = period_running_reg;
        period_ps_next       = period_ps_reg;
        width_count_next     = width_count_reg;
        width_reload_next    = width_reload_reg;
        width_prepared_next  = width_prepared_reg;
        width_running_next   = width_running_reg;
        width_ps_next        = width_ps_reg;
        level_next           = level_reg;
        started              = 1'b0;
        ended                = 1'b0;

        unique case (kind_t'(item.kind))
            KIND_TICK:
            begin
                // Step the width counter first
                if (width_running_reg)
                begin
                    if (width_ps_reg >= prescale_div_reg)
                    begin
                        width_ps_next = '0;
                        if (width_count_reg >= width_reload_reg)
                        begin
                            width_count_next   = '0;
                            width_running_next = 1'b0;
                            width_reload_next  = width_prepared_reg;
                            level_next         = 1'b0;
                            ended              = 1'b1;
                        end
                        else
                        begin
                            width_count_next = width_count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        width_ps_next = width_ps_reg + 1'b1;
                    end
                end
                // Then the period counter; a wrap fires the width counter
                if (period_running_reg)
                begin
                    if (period_ps_reg >= prescale_div_reg)
                    begin
                        period_ps_next = '0;
                        if (period_count_reg >= period_reload_reg)
                        begin
                            period_count_next  = '0;
                            period_reload_next = period_prepared_reg;
                            width_running_next = 1'b1;
                            level_next         = 1'b1;
                            started            = 1'b1;
                        end
                        else
                        begin
                            period_count_next = period_count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        period_ps_next = period_ps_reg + 1'b1;
                    end
                end
            end
            KIND_START:
            begin
                period_prepared_next = period_sat;
                period_reload_next   = period_sat;
                width_prepared_next  = width_sat;
                width_reload_next    = width_sat;
                period_running_next  = 1'b1;
                width_running_next   = 1'b1;
                level_next           = 1'b1;
                started              = 1'b1;
            end
            KIND_STOP:
            begin
                period_running_next = 1'b0;
                width_running_next  = 1'b0;
            end
            KIND_SET_PERIOD:
            begin
                if (item.period_value < PERIOD_LIMIT)
                begin
                    if (item.period_value == '0)
                    begin
                        period_running_next = 1'b0;
                    end
                    else
                    begin
                        period_prepared_next = item.period_value;
                        period_running_next  = 1'b1;
                    end
                end
            end
            KIND_SET_WIDTH:
            begin
                if (item.width_value < WIDTH_LIMIT)
                begin
                    if (item.width_value == '0)
                    begin
                        width_running_next = 1'b0;
                    end
                    else
                    begin
                        width_prepared_next = item.width_value;
                        width_running_next  = 1'b1;
                    end
                end
            end
            default:
            begin
                // Unused kinds change nothing
            end
        endcase
    end

    assign result.pulse_level    = level_next;
    assign result.period_started = started;
    assign result.width_ended    = ended;

    // Hold state; advance on each processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_div_reg    <= PRESCALE_RESET;
            period_count_reg    <= '0;
            period_reload_reg   <= PERIOD_RELOAD_RESET;
            period_prepared_reg <= '0;
            period_running_reg  <= 1'b0;
            period_ps_reg       <= '0;
            width_count_reg     <= '0;
            width_reload_reg    <= WIDTH_RELOAD_RESET;
            width_prepared_reg  <= '0;
            width_running_reg   <= 1'b0;
            width_ps_reg        <= '0;
            level_reg           <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                prescale_div_reg <= cfg_data;
            end
            if (step_en)
            begin
                period_count_reg    <= period_count_next;
                period_reload_reg   <= period_reload_next;
                period_prepared_reg <= period_prepared_next;
                period_running_reg  <= period_running_next;
                period_ps_reg       <= period_ps_next;
                width_count_reg     <= width_count_next;
                width_reload_reg    <= width_reload_next;
                width_prepared_reg  <= width_prepared_next;
                width_running_reg   <= width_running_next;
                width_ps_reg        <= width_ps_next;
                level_reg           <= level_next;
            end
        end
    end

endmodule

// File: design/pulse_period_width_generator.sv
// ----------------------------------------------------------------------------
// pulse_period_width_generator
// An accepted item is held in the input register until the result register is
// free or being taken; ppwg_core then applies it and its result is registered.
// Throughput: one item per cycle unless m_tready stalls the output; the counter
// state in ppwg_core is updated once per item as it enters the result register.
// Reset (rst_n, asynchronous, active low) stops both counters, drives the
// level low, restores the default reload values and sets prescale to 83.
// ----------------------------------------------------------------------------
module pulse_period_width_generator (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input item stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // period_value[19:0], width_value[29:20]
    input  logic [ppwg_pkg::KIND_W-1:0]     s_tuser,   // kind[2:0]
    // Result item stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // pulse_level[0], period_started[1],
                                                       // width_ended[2]
    // Prescale register write
    input  logic                            cfg_we,
    input  logic [ppwg_pkg::PRESCALE_W-1:0] cfg_data
);
    import ppwg_pkg::*;

    logic         in_valid_reg;
    ppwg_item_t   in_item_reg;
    logic         out_valid_reg;
    ppwg_result_t out_result_reg;
    ppwg_result_t step_result;
    logic         advance;

    // Move an item to the result register when that slot is free or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    ppwg_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_en  (advance),
        .item     (in_item_reg),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .result   (step_result)
    );

    // Input register: hold the accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.kind         <= s_tuser;
            in_item_reg.period_value <= s_tdata[PERIOD_W-1:0];
            in_item_reg.width_value  <= s_tdata[PERIOD_W+WIDTH_W-1:PERIOD_W];
        end
    end

    // Result register: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_result_reg.width_ended, out_result_reg.period_started,
                       out_result_reg.pulse_level};

endmodule
